// ----- src/sbds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbds_pkg
// Shared types and constants for the shared-buffer dual stack: operation
// codes, status codes, controller states and the controller command bundle.
// ----------------------------------------------------------------------------
package sbds_pkg;

   // default sizing
   localparam int DEPTH_DEFAULT     = 8;
   localparam int WORD_BITS_DEFAULT = 32;

   // fixed field widths of the request and response
   localparam int OP_BITS     = 2;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 4;

   // requested operation
   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH_LOW  = 2'd0,
      OP_POP_LOW   = 2'd1,
      OP_PUSH_HIGH = 2'd2,
      OP_POP_HIGH  = 2'd3
   } op_type;

   // response status codes
   localparam logic [STATUS_BITS-1:0] STS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STS_EMPTY = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request fields
      logic execute;   // perform the push or pop
   } dp_cmd_type;

endpackage
`default_nettype wire

// ----- src/sbds_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbds_ctrl
// Sequencer for one request: capture, execute against the buffer, then
// present the response for one cycle.
// ----------------------------------------------------------------------------
module sbds_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output sbds_pkg::dp_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import sbds_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         S_EXEC: cmd.execute = 1'b1;
         S_RESP: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

// ----- src/sbds_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbds_dp
// Datapath: request registers, the two stack pointers, the shared word
// buffer and the response registers.
// ----------------------------------------------------------------------------
module sbds_dp #(
   parameter int DEPTH     = sbds_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = sbds_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sbds_pkg::dp_cmd_type                cmd,
   input  wire logic [sbds_pkg::OP_BITS-1:0]        req_operation,
   input  wire logic signed [sbds_pkg::VALUE_BITS-1:0] req_push_value,
   output logic signed [sbds_pkg::VALUE_BITS-1:0]   rsp_pop_value,
   output logic [sbds_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [sbds_pkg::COUNT_BITS-1:0]          rsp_low_count,
   output logic [sbds_pkg::COUNT_BITS-1:0]          rsp_high_count
);
   import sbds_pkg::*;

   localparam int PTR_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);

   // request registers
   op_type                       op_ff;
   logic [VALUE_BITS-1:0]        value_ff;

   // stack pointers: low_top is the low stack's size, high_top the high stack's top index
   logic [PTR_W-1:0]             low_top_ff;
   logic [PTR_W-1:0]             low_top_in;
   logic [PTR_W-1:0]             high_top_ff;
   logic [PTR_W-1:0]             high_top_in;

   // response registers
   logic [STATUS_BITS-1:0]       status_ff;
   logic [STATUS_BITS-1:0]       status_in;
   logic                         use_rd_ff;
   logic                         use_rd_in;

   // buffer
   logic [WORD_BITS-1:0]         mem [DEPTH];
   logic [WORD_BITS-1:0]         rd_data_ff;
   logic                         wr_en;
   logic                         rd_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            rd_addr;
   logic [WORD_BITS-1:0]         wr_data;
   logic [WORD_BITS+VALUE_BITS-1:0] wr_ext;
   logic [WORD_BITS+VALUE_BITS-1:0] rd_ext;
   logic [PTR_W-1:0]             low_dec;
   logic [PTR_W-1:0]             high_dec;
   logic [PTR_W-1:0]             high_used;
   logic [PTR_W+COUNT_BITS-1:0]  low_cnt_ext;
   logic [PTR_W+COUNT_BITS-1:0]  high_cnt_ext;
   logic                         full;

   // capture the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_operation);
         value_ff <= req_push_value;
      end
   end

   // word width adaptation
   assign wr_ext  = {{WORD_BITS{1'b0}}, value_ff};
   assign wr_data = wr_ext[WORD_BITS-1:0];
   assign rd_ext  = {{VALUE_BITS{1'b0}}, rd_data_ff};

   assign low_dec  = low_top_ff - PTR_ONE;
   assign high_dec = high_top_ff - PTR_ONE;
   // the tops meet when the buffer holds DEPTH words
   assign full     = (low_top_ff == high_top_ff);

   // operation decode
   always_comb begin
      low_top_in  = low_top_ff;
      high_top_in = high_top_ff;
      status_in   = STS_DONE;
      use_rd_in   = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      wr_addr     = low_top_ff[ADDR_W-1:0];
      rd_addr     = high_top_ff[ADDR_W-1:0];
      unique case (op_ff)
         OP_PUSH_LOW: begin
            if (full) begin
               status_in = STS_FULL;
            end else begin
               wr_en      = 1'b1;
               wr_addr    = low_top_ff[ADDR_W-1:0];
               low_top_in = low_top_ff + PTR_ONE;
            end
         end
         OP_POP_LOW: begin
            if (low_top_ff == '0) begin
               status_in = STS_EMPTY;
            end else begin
               rd_en      = 1'b1;
               use_rd_in  = 1'b1;
               rd_addr    = low_dec[ADDR_W-1:0];
               low_top_in = low_dec;
            end
         end
         OP_PUSH_HIGH: begin
            if (full) begin
               status_in = STS_FULL;
            end else begin
               wr_en       = 1'b1;
               wr_addr     = high_dec[ADDR_W-1:0];
               high_top_in = high_dec;
            end
         end
         OP_POP_HIGH: begin
            if (high_top_ff == PTR_DEPTH) begin
               status_in = STS_EMPTY;
            end else begin
               rd_en       = 1'b1;
               use_rd_in   = 1'b1;
               rd_addr     = high_top_ff[ADDR_W-1:0];
               high_top_in = high_top_ff + PTR_ONE;
            end
         end
         default: status_in = STS_DONE;
      endcase
   end

   // pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_top_ff  <= '0;
         high_top_ff <= PTR_DEPTH;
      end else if (cmd.execute) begin
         low_top_ff  <= low_top_in;
         high_top_ff <= high_top_in;
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         use_rd_ff <= use_rd_in;
      end
   end

   // shared buffer, registered read
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.execute && rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // response fields
   assign high_used    = PTR_DEPTH - high_top_ff;
   assign low_cnt_ext  = {{COUNT_BITS{1'b0}}, low_top_ff};
   assign high_cnt_ext = {{COUNT_BITS{1'b0}}, high_used};

   always_comb begin
      priority if (use_rd_ff) begin
         rsp_pop_value = rd_ext[VALUE_BITS-1:0];
      end else if (status_ff == STS_EMPTY) begin
         rsp_pop_value = '1;
      end else begin
         rsp_pop_value = '0;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_low_count  = low_cnt_ext[COUNT_BITS-1:0];
   assign rsp_high_count = high_cnt_ext[COUNT_BITS-1:0];

endmodule
`default_nettype wire

// ----- src/shared_buffer_dual_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shared_buffer_dual_stack
// Two LIFO stacks in one buffer of DEPTH words; the low stack grows up from
// entry 0, the high stack grows down from the top entry.
//
// Usage:
//   - request: drive req_operation and req_push_value with start high; the
//     transfer happens at the edge where start is high and busy is low.
//   - operations: push low, pop low, push high, pop high.
//   - response: rsp_valid is high for exactly one cycle with rsp_pop_value,
//     rsp_status (done, full, empty) and both stacks' occupancies.
//   - timing: after the transfer the sequencer moves to its execute state
//     (buffer access, registered read port), then to the response state;
//     busy is held through both, so one request is served at a time.
//   - a push with the tops meeting is refused with status full; a pop of an
//     empty stack is refused with status empty and value all ones.
//   - reset empties both stacks; buffer contents are not cleared and need
//     no clearing pass.
//   - the receiver cannot stall: each response is taken in its one cycle.
// ----------------------------------------------------------------------------
module shared_buffer_dual_stack #(
   parameter int DEPTH     = sbds_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = sbds_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic [sbds_pkg::OP_BITS-1:0]           req_operation,
   input  wire logic signed [sbds_pkg::VALUE_BITS-1:0] req_push_value,
   output logic                                        rsp_valid,
   output logic signed [sbds_pkg::VALUE_BITS-1:0]      rsp_pop_value,
   output logic [sbds_pkg::STATUS_BITS-1:0]            rsp_status,
   output logic [sbds_pkg::COUNT_BITS-1:0]             rsp_low_count,
   output logic [sbds_pkg::COUNT_BITS-1:0]             rsp_high_count
);
   import sbds_pkg::*;

   dp_cmd_type cmd;

   // sequencer
   sbds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // pointers and buffer
   sbds_dp #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_operation),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_low_count  (rsp_low_count),
      .rsp_high_count (rsp_high_count)
   );

endmodule
`default_nettype wire
